// File: rtl/core/jsu_pkg.sv
// ----------------------------------------------------------------------------
// JSON string unescape package
// Shared types, codes and decode helpers for the string unescape block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

  localparam int MAX_RESULTS = 4;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);

  localparam logic [7:0] CHAR_QUOTE     = 8'h22;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
  localparam logic [7:0] CHAR_SLASH     = 8'h2f;
  localparam logic [7:0] CHAR_U         = 8'h75;

  typedef enum logic [2:0] {
    PH_PLAIN  = 3'd0,
    PH_ESC    = 3'd1,
    PH_HEX1   = 3'd2,
    PH_HEX2   = 3'd3,
    PH_HEX3   = 3'd4,
    PH_HEX4   = 3'd5,
    PH_DONE   = 3'd6,
    PH_POISON = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    KIND_DATA   = 3'd0,
    KIND_CLOSED = 3'd1,
    KIND_BADESC = 3'd2,
    KIND_BADHEX = 3'd3,
    KIND_TRUNC  = 3'd4
  } kind_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
  } result_t;

  // All results caused by one input byte.
  typedef struct packed {
    logic [2:0]                     count;
    result_t [MAX_RESULTS-1:0]      res;
  } pkt_t;

  // Returns {valid, value}.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, c[3:0]};
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // Returns {valid, byte} for the single-byte escape letters.
  function automatic logic [8:0] escape_byte(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      CHAR_QUOTE:     r = {1'b1, 8'h22};
      CHAR_BACKSLASH: r = {1'b1, 8'h5c};
      CHAR_SLASH:     r = {1'b1, 8'h2f};
      8'h62:          r = {1'b1, 8'h08};
      8'h66:          r = {1'b1, 8'h0c};
      8'h6e:          r = {1'b1, 8'h0a};
      8'h72:          r = {1'b1, 8'h0d};
      8'h74:          r = {1'b1, 8'h09};
      default:        r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/jsu_front.sv
// ----------------------------------------------------------------------------
// JSON string unescape front end
// Accepts raw bytes, tracks the escape phase and builds one result packet
// per byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jsu_front (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        take,
  input  wire logic [7:0]  in_byte,
  input  wire logic        end_of_input,
  output jsu_pkg::pkt_t    pkt
);

  jsu_pkg::phase_t phase, phase_next;
  logic [15:0]     code_point, code_point_next;

  logic [4:0]  hx;
  logic [8:0]  esc;
  logic [15:0] cp_full;
  logic [1:0]  poison_left;

  assign hx          = jsu_pkg::hex_digit(in_byte);
  assign esc         = jsu_pkg::escape_byte(in_byte);
  assign cp_full     = {code_point[11:0], hx[3:0]};
  assign poison_left = code_point[1:0];

  // Next phase and gathered hex value.
  always_comb begin
    phase_next      = phase;
    code_point_next = code_point;
    case (phase)
      jsu_pkg::PH_PLAIN: begin
        if (in_byte == jsu_pkg::CHAR_QUOTE) begin
          phase_next = jsu_pkg::PH_DONE;
        end else if (in_byte == jsu_pkg::CHAR_BACKSLASH) begin
          phase_next = end_of_input ? jsu_pkg::PH_DONE : jsu_pkg::PH_ESC;
        end else if (end_of_input) begin
          phase_next = jsu_pkg::PH_DONE;
        end
      end
      jsu_pkg::PH_ESC: begin
        if (in_byte == jsu_pkg::CHAR_U) begin
          code_point_next = 16'd0;
          phase_next = end_of_input ? jsu_pkg::PH_DONE : jsu_pkg::PH_HEX1;
        end else if (!esc[8] || end_of_input) begin
          phase_next = jsu_pkg::PH_DONE;
        end else begin
          phase_next = jsu_pkg::PH_PLAIN;
        end
      end
      jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2, jsu_pkg::PH_HEX3, jsu_pkg::PH_HEX4: begin
        if (!hx[4]) begin
          if (phase == jsu_pkg::PH_HEX4 || end_of_input) begin
            phase_next = jsu_pkg::PH_DONE;
          end else begin
            // Remember how many digit positions are still to come.
            code_point_next = {13'd0, jsu_pkg::PH_HEX4 - phase};
            phase_next      = jsu_pkg::PH_POISON;
          end
        end else if (phase == jsu_pkg::PH_HEX4) begin
          code_point_next = 16'd0;
          phase_next = end_of_input ? jsu_pkg::PH_DONE : jsu_pkg::PH_PLAIN;
        end else begin
          code_point_next = cp_full;
          phase_next = end_of_input ? jsu_pkg::PH_DONE : jsu_pkg::phase_t'(phase + 3'd1);
        end
      end
      jsu_pkg::PH_POISON: begin
        if (poison_left <= 2'd1 || end_of_input) begin
          phase_next = jsu_pkg::PH_DONE;
        end else begin
          code_point_next = {14'd0, poison_left - 2'd1};
        end
      end
      default: phase_next = jsu_pkg::PH_DONE;
    endcase
  end

  // Result packet for the current byte.
  always_comb begin
    logic [1:0] ulen;
    ulen = 2'd1;
    pkt  = '0;
    case (phase)
      jsu_pkg::PH_PLAIN: begin
        if (in_byte == jsu_pkg::CHAR_QUOTE) begin
          pkt.res[0].kind = jsu_pkg::KIND_CLOSED;
          pkt.count       = 3'd1;
        end else if (in_byte == jsu_pkg::CHAR_BACKSLASH) begin
          if (end_of_input) begin
            pkt.res[0].kind = jsu_pkg::KIND_TRUNC;
            pkt.count       = 3'd1;
          end
        end else begin
          pkt.res[0].data = in_byte;
          pkt.res[1].kind = jsu_pkg::KIND_TRUNC;
          pkt.count       = end_of_input ? 3'd2 : 3'd1;
        end
      end
      jsu_pkg::PH_ESC: begin
        if (in_byte == jsu_pkg::CHAR_U) begin
          if (end_of_input) begin
            pkt.res[0].kind = jsu_pkg::KIND_TRUNC;
            pkt.count       = 3'd1;
          end
        end else if (!esc[8]) begin
          pkt.res[0].kind = jsu_pkg::KIND_BADESC;
          pkt.count       = 3'd1;
        end else begin
          pkt.res[0].data = esc[7:0];
          pkt.res[1].kind = jsu_pkg::KIND_TRUNC;
          pkt.count       = end_of_input ? 3'd2 : 3'd1;
        end
      end
      jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2, jsu_pkg::PH_HEX3, jsu_pkg::PH_HEX4: begin
        if (!hx[4]) begin
          if (phase == jsu_pkg::PH_HEX4) begin
            pkt.res[0].kind = jsu_pkg::KIND_BADHEX;
            pkt.count       = 3'd1;
          end else if (end_of_input) begin
            pkt.res[0].kind = jsu_pkg::KIND_TRUNC;
            pkt.count       = 3'd1;
          end
        end else if (phase == jsu_pkg::PH_HEX4) begin
          // UTF-8 encoding of the 16-bit code point.
          if (cp_full <= 16'h007f) begin
            ulen = 2'd1;
            pkt.res[0].data = cp_full[7:0];
          end else if (cp_full <= 16'h07ff) begin
            ulen = 2'd2;
            pkt.res[0].data = 8'hc0 | {3'd0, cp_full[10:6]};
            pkt.res[1].data = 8'h80 | {2'd0, cp_full[5:0]};
          end else begin
            ulen = 2'd3;
            pkt.res[0].data = 8'he0 | {4'd0, cp_full[15:12]};
            pkt.res[1].data = 8'h80 | {2'd0, cp_full[11:6]};
            pkt.res[2].data = 8'h80 | {2'd0, cp_full[5:0]};
          end
          pkt.count = {1'b0, ulen};
          if (end_of_input) begin
            pkt.res[ulen] = '{data: 8'd0, kind: jsu_pkg::KIND_TRUNC};
            pkt.count     = {1'b0, ulen} + 3'd1;
          end
        end else if (end_of_input) begin
          pkt.res[0].kind = jsu_pkg::KIND_TRUNC;
          pkt.count       = 3'd1;
        end
      end
      jsu_pkg::PH_POISON: begin
        if (poison_left <= 2'd1) begin
          pkt.res[0].kind = jsu_pkg::KIND_BADHEX;
          pkt.count       = 3'd1;
        end else if (end_of_input) begin
          pkt.res[0].kind = jsu_pkg::KIND_TRUNC;
          pkt.count       = 3'd1;
        end
      end
      default: pkt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= jsu_pkg::PH_PLAIN;
      code_point <= 16'd0;
    end else if (take) begin
      phase      <= phase_next;
      code_point <= code_point_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/jsu_queue.sv
// ----------------------------------------------------------------------------
// JSON string unescape packet queue
// Short register queue of result packets between front and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jsu_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire jsu_pkg::pkt_t  push_pkt,
  input  wire logic           pop,
  output jsu_pkg::pkt_t       head,
  output logic                full,
  output logic                empty
);

  jsu_pkg::pkt_t                 slots [jsu_pkg::QDEPTH];
  logic [jsu_pkg::QPTR_W-1:0]    wr_ptr;
  logic [jsu_pkg::QPTR_W-1:0]    rd_ptr;
  logic [jsu_pkg::QPTR_W:0]      fill;

  assign full  = (fill == (jsu_pkg::QPTR_W + 1)'(jsu_pkg::QDEPTH));
  assign empty = (fill == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_pkt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/jsu_back.sv
// ----------------------------------------------------------------------------
// JSON string unescape back end
// Walks each queued packet and sends its results one per cycle while
// out_stall is low, through a registered output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jsu_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire jsu_pkg::pkt_t  head,
  input  wire logic           empty,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [7:0]          out_byte,
  output logic [2:0]          kind,
  output logic                run_last
);

  logic [1:0] pos;
  logic       load;
  logic       last;

  assign load = !empty && (!out_valid || !out_stall);
  assign last = ({1'b0, pos} == (head.count - 3'd1));
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        pos       <= last ? 2'd0 : pos + 2'd1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= head.res[pos].data;
      kind     <= head.res[pos].kind;
      run_last <= last;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/json_string_unescape_utf8_top.sv
// ----------------------------------------------------------------------------
// JSON string unescape, UTF-8 output
// Streaming decoder for the body of a JSON string literal.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, in_byte, end_of_input) carries one
//   raw byte per transfer, starting just after the opening quote. Set
//   end_of_input on the last byte of the available text.
//   The output channel (out_valid, out_stall, out_byte, kind, run_last)
//   carries one result per transfer: a decoded data byte (kind 0) or a
//   status (closed, bad escape, bad hex digit, truncated). run_last marks
//   the last result caused by one input byte; bytes that cause no result
//   (a backslash, the first hex digits) produce no transfer.
//   Throughput: one input byte per cycle while in_stall is low. Each input
//   byte is decoded in the cycle it is taken and its packet of up to four
//   results enters a four-entry queue; the back end sends one result per
//   cycle while out_stall is low, so a byte holds the output for one
//   transfer per result. Save for the truncated status at end of input, the
//   output never outgrows the input count, so the queue keeps the input at
//   full rate. in_stall rises only when the queue is full, which happens
//   when the receiver holds out_stall. Reset returns the decoder to plain
//   text, empties the queue and drops out_valid. After a close or an error,
//   later bytes are taken and ignored until reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape_utf8_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       end_of_input,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic [2:0]      kind,
  output logic            run_last
);

  jsu_pkg::pkt_t front_pkt;
  jsu_pkg::pkt_t head;
  logic          take;
  logic          push;
  logic          pop;
  logic          full;
  logic          empty;

  // A byte transfer completes whenever the queue has room.
  assign in_stall = full;
  assign take     = in_valid && !full;
  // Only bytes that cause at least one result occupy a queue slot.
  assign push     = take && (front_pkt.count != 3'd0);

  jsu_front u_front (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .in_byte      (in_byte),
    .end_of_input (end_of_input),
    .pkt          (front_pkt)
  );

  jsu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_pkt (front_pkt),
    .pop      (pop),
    .head     (head),
    .full     (full),
    .empty    (empty)
  );

  jsu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .kind      (kind),
    .run_last  (run_last)
  );

endmodule

`default_nettype wire
